// ===== rtl/calendar_date_adder_macros.svh =====
// ----------------------------------------------------------------------------
// calendar date adder assertion macros
// shared property wrappers for the date adder checks
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADDER_MACROS_SVH
`define CALENDAR_DATE_ADDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// types, codes and calendar helpers for the calendar date adder
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

   localparam logic [13:0] YEAR_MAX        = 14'd9999;
   localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
   localparam logic [4:0]  DAYS_FEB        = 5'd28;
   localparam logic [4:0]  DAYS_SHORT      = 5'd30;
   localparam logic [4:0]  DAYS_LONG       = 5'd31;
   localparam logic [27:0] DIV100_MUL      = 28'd5243;
   localparam logic [31:0] DIV12_MUL       = 32'd43691;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 14;

   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_DAY   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_MONTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_YEAR  = 2'd2;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_DAYS   = 2'd1,
      FUNC_MONTHS = 2'd2,
      FUNC_YEARS  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_BAD_MONTH = 2'd1,
      STS_BAD_DAY   = 2'd2,
      STS_YEAR      = 2'd3
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [4:0]  load_day;
      logic [3:0]  load_month;
      logic [13:0] load_year;
      logic [15:0] amount;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [13:0] cur_year;
      status_type  status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      CMD_IDLE    = 3'd0,
      CMD_CAPTURE = 3'd1,
      CMD_CHECK   = 3'd2,
      CMD_DAY     = 3'd3,
      CMD_MDIV    = 3'd4,
      CMD_MFIX    = 3'd5,
      CMD_YEAR    = 3'd6
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      func_type   func;
   } cmd_type;

   typedef struct packed {
      logic day_end;
   } sts_type;

   // y / 100 by reciprocal, exact for all 14-bit years
   function automatic logic is_leap(input logic [13:0] y);
      logic [27:0] prod;
      logic [8:0]  quot;
      logic [15:0] quot100;
      logic [15:0] rem;
      begin
         prod    = {14'd0, y} * DIV100_MUL;
         quot    = prod[27:19];
         quot100 = {1'b0, quot, 6'd0} + {2'b0, quot, 5'd0} + {5'b0, quot, 2'd0};
         rem     = {2'b0, y} - quot100;
         is_leap = ((y[1:0] == 2'd0) && (rem != 16'd0)) ||
                   ((rem == 16'd0) && (quot[1:0] == 2'd0));
      end
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
      logic [4:0] len;
      begin
         case (m) inside
            4'd2:                                   len = DAYS_FEB + {4'd0, is_leap(y)};
            4'd4, 4'd6, 4'd9, 4'd11:                len = DAYS_SHORT;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
            default:                                len = 5'd0;
         endcase
         month_len = len;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_adder.sv =====
// states from accept to strobe: load capture, check, done; add years capture, year,
// done; add months capture, mdiv, mfix, year, done; add days capture, day steps to a
// fit or year overflow, done; one item at a time: next accept the cycle after the result
// the result strobe is one cycle wide and cannot be stalled
// synchronous reset: held date 1 june 1970, defaults the same, controller idle
// ----------------------------------------------------------------------------
// calendar_date_adder
// holds one gregorian date and loads it or adds days, months or years
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_adder_macros.svh"

module calendar_date_adder (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  cda_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   output cda_pkg::rsp_word_type            rsp_word,
   input  wire                              csr_we,
   input  wire  [cda_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire  [cda_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cda_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .func      (req_word.func),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   cda_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_word  (rsp_word)
   );

   `CDA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `CDA_ASSERT_NOW(a_rsp_in_busy, clock, reset, rsp_valid, busy, "result strobe outside busy")
   `CDA_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid && !busy, "result strobe longer than one cycle")
   `CDA_ASSERT_NOW(a_month_range, clock, reset, rsp_valid, rsp_word.cur_month >= 4'd1 && rsp_word.cur_month <= 4'd12, "held month out of range")

endmodule

`default_nettype wire

// ===== rtl/cda_dp.sv =====
// ----------------------------------------------------------------------------
// cda_dp
// datapath: held date, defaults, working date and the calendar arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module cda_dp (
   input  wire                              clock,
   input  wire                              reset,
   input  cda_pkg::cmd_type                 cmd,
   output cda_pkg::sts_type                 sts,
   input  cda_pkg::req_word_type            req_word,
   input  wire                              csr_we,
   input  wire  [cda_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire  [cda_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cda_pkg::rsp_word_type            rsp_word
);
   import cda_pkg::*;

   logic [4:0]  def_day_ff,   def_day_in;
   logic [3:0]  def_month_ff, def_month_in;
   logic [13:0] def_year_ff,  def_year_in;
   logic [4:0]  held_day_ff,  held_day_in;
   logic [3:0]  held_month_ff, held_month_in;
   logic [13:0] held_year_ff, held_year_in;
   logic [4:0]  wd_ff, wd_in;
   logic [3:0]  wm_ff, wm_in;
   logic [13:0] wy_ff, wy_in;
   logic [15:0] left_ff, left_in;
   logic [31:0] prod_ff, prod_in;
   status_type  status_ff, status_in;

   logic [4:0]  len_cur;
   logic [16:0] sum_day;
   logic        day_fit;
   logic        day_ovf;
   logic [15:0] day_used;
   logic [12:0] quot;
   logic [16:0] quot12;
   logic [16:0] rem_full;
   logic [4:0]  mon_sum;
   logic [4:0]  mon_wrap;
   logic [3:0]  mon_new;
   logic [13:0] carry;
   logic [4:0]  len_new;
   logic [16:0] year_sum;
   logic        year_ovf;
   logic [4:0]  len_ny;

   always_comb begin
      len_cur  = month_len(wm_ff, wy_ff);
      sum_day  = {1'b0, left_ff} + {12'd0, wd_ff};
      day_fit  = sum_day <= {12'd0, len_cur};
      day_ovf  = !day_fit && (wm_ff == MONTHS_PER_YEAR) && (wy_ff == YEAR_MAX);
      day_used = {11'd0, len_cur} - {11'd0, wd_ff} + 16'd1;

      quot     = prod_ff[31:19];
      quot12   = {1'b0, quot, 3'd0} + {2'b0, quot, 2'd0};
      rem_full = {1'b0, left_ff} - quot12;
      mon_sum  = {1'b0, wm_ff} + {1'b0, rem_full[3:0]};
      mon_wrap = mon_sum - {1'b0, MONTHS_PER_YEAR};
      if (mon_sum > {1'b0, MONTHS_PER_YEAR}) begin
         mon_new = mon_wrap[3:0];
         carry   = {1'b0, quot} + 14'd1;
      end else begin
         mon_new = mon_sum[3:0];
         carry   = {1'b0, quot};
      end
      len_new  = month_len(mon_new, wy_ff);

      year_sum = {3'd0, wy_ff} + {1'b0, left_ff};
      year_ovf = year_sum > {3'd0, YEAR_MAX};
      len_ny   = month_len(wm_ff, year_sum[13:0]);
   end

   assign sts.day_end = day_fit || day_ovf;

   always_comb begin
      def_day_in    = def_day_ff;
      def_month_in  = def_month_ff;
      def_year_in   = def_year_ff;
      held_day_in   = held_day_ff;
      held_month_in = held_month_ff;
      held_year_in  = held_year_ff;
      wd_in         = wd_ff;
      wm_in         = wm_ff;
      wy_in         = wy_ff;
      left_in       = left_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_DEFAULT_DAY:   def_day_in   = csr_wdata[4:0];
            CSR_DEFAULT_MONTH: def_month_in = csr_wdata[3:0];
            CSR_DEFAULT_YEAR:  def_year_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (cmd.op)
         CMD_CAPTURE: begin
            left_in   = req_word.amount;
            status_in = STS_OK;
            if (cmd.func == FUNC_LOAD) begin
               wd_in = (req_word.load_day   != 5'd0)  ? req_word.load_day   : def_day_ff;
               wm_in = (req_word.load_month != 4'd0)  ? req_word.load_month : def_month_ff;
               wy_in = (req_word.load_year  != 14'd0) ? req_word.load_year  : def_year_ff;
            end else begin
               wd_in = held_day_ff;
               wm_in = held_month_ff;
               wy_in = held_year_ff;
            end
         end
         CMD_CHECK: begin
            if (wm_ff < 4'd1 || wm_ff > MONTHS_PER_YEAR) begin
               status_in = STS_BAD_MONTH;
            end else if (wd_ff < 5'd1 || wd_ff > len_cur) begin
               status_in = STS_BAD_DAY;
            end else if (wy_ff < 14'd1 || wy_ff > YEAR_MAX) begin
               status_in = STS_YEAR;
            end else begin
               status_in     = STS_OK;
               held_day_in   = wd_ff;
               held_month_in = wm_ff;
               held_year_in  = wy_ff;
            end
         end
         CMD_DAY: begin
            if (day_fit) begin
               status_in     = STS_OK;
               held_day_in   = sum_day[4:0];
               held_month_in = wm_ff;
               held_year_in  = wy_ff;
            end else if (day_ovf) begin
               status_in = STS_YEAR;
            end else begin
               left_in = left_ff - day_used;
               wd_in   = 5'd1;
               if (wm_ff == MONTHS_PER_YEAR) begin
                  wm_in = 4'd1;
                  wy_in = wy_ff + 14'd1;
               end else begin
                  wm_in = wm_ff + 4'd1;
               end
            end
         end
         CMD_MDIV: begin
            prod_in = {16'd0, left_ff} * DIV12_MUL;
         end
         CMD_MFIX: begin
            wm_in   = mon_new;
            wd_in   = (wd_ff > len_new) ? len_new : wd_ff;
            left_in = {2'd0, carry};
         end
         CMD_YEAR: begin
            if (left_ff == 16'd0) begin
               status_in     = STS_OK;
               held_day_in   = wd_ff;
               held_month_in = wm_ff;
               held_year_in  = wy_ff;
            end else if (year_ovf) begin
               status_in = STS_YEAR;
            end else begin
               status_in     = STS_OK;
               held_month_in = wm_ff;
               held_year_in  = year_sum[13:0];
               if (wd_ff == len_cur && is_leap(wy_ff) != is_leap(year_sum[13:0])) begin
                  held_day_in = len_ny;
               end else begin
                  held_day_in = wd_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         def_day_ff    <= 5'd1;
         def_month_ff  <= 4'd6;
         def_year_ff   <= 14'd1970;
         held_day_ff   <= 5'd1;
         held_month_ff <= 4'd6;
         held_year_ff  <= 14'd1970;
         status_ff     <= STS_OK;
      end else begin
         def_day_ff    <= def_day_in;
         def_month_ff  <= def_month_in;
         def_year_ff   <= def_year_in;
         held_day_ff   <= held_day_in;
         held_month_ff <= held_month_in;
         held_year_ff  <= held_year_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      wd_ff   <= wd_in;
      wm_ff   <= wm_in;
      wy_ff   <= wy_in;
      left_ff <= left_in;
      prod_ff <= prod_in;
   end

   assign rsp_word.cur_day   = held_day_ff;
   assign rsp_word.cur_month = held_month_ff;
   assign rsp_word.cur_year  = held_year_ff;
   assign rsp_word.status    = status_ff;

endmodule

`default_nettype wire

// ===== rtl/cda_ctrl.sv =====
// ----------------------------------------------------------------------------
// cda_ctrl
// controller: sequences load check, day walk, month and year adds
// ----------------------------------------------------------------------------
`default_nettype none

module cda_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  cda_pkg::func_type  func,
   input  cda_pkg::sts_type   sts,
   output cda_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import cda_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_DAY  = 7'b0000100,
      S_MDIV = 7'b0001000,
      S_MFIX = 7'b0010000,
      S_YEAR = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = CMD_IDLE;
      cmd.func = func;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = CMD_CAPTURE;
               unique case (func)
                  FUNC_LOAD:   state_in = S_LOAD;
                  FUNC_DAYS:   state_in = S_DAY;
                  FUNC_MONTHS: state_in = S_MDIV;
                  FUNC_YEARS:  state_in = S_YEAR;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.op   = CMD_CHECK;
            state_in = S_DONE;
         end
         S_DAY: begin
            cmd.op = CMD_DAY;
            if (sts.day_end) begin
               state_in = S_DONE;
            end
         end
         S_MDIV: begin
            cmd.op   = CMD_MDIV;
            state_in = S_MFIX;
         end
         S_MFIX: begin
            cmd.op   = CMD_MFIX;
            state_in = S_YEAR;
         end
         S_YEAR: begin
            cmd.op   = CMD_YEAR;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

`default_nettype wire

// ===== sim/calendar_date_adder_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_date_adder_tb
// Drives load and add-days/months/years words into the date adder and checks
// every result word against a shadow calendar kept in the testbench. The run
// starts with directed corner dates, then runs random phases, each with
// different default-date registers; the sender idling varies across phases.
// ----------------------------------------------------------------------------
module calendar_date_adder_tb;
   import cda_pkg::*;

   class date_shadow;
      int unsigned dflt_day, dflt_month, dflt_year;
      int unsigned day, month, year;
      rsp_word_type pending[$];
      int unsigned errors, checked;
      int unsigned seen[4];

      function new();
         dflt_day = 1;
         dflt_month = 6;
         dflt_year = 1970;
         day = 1;
         month = 6;
         year = 1970;
         errors = 0;
         checked = 0;
         foreach (seen[i]) seen[i] = 0;
      endfunction

      function bit leap(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int unsigned span(int unsigned m, int unsigned y);
         case (m)
            2: return DAYS_FEB + leap(y);
            4, 6, 9, 11: return DAYS_SHORT;
            1, 3, 5, 7, 8, 10, 12: return DAYS_LONG;
            default: return 0;
         endcase
      endfunction

      // end-of-month day follows the leap status of the new year
      function bit shift_years(inout int unsigned d, input int unsigned m,
                               inout int unsigned y, input int unsigned n);
         int unsigned ny;
         if (n == 0) return 1'b1;
         ny = y + n;
         if (ny > YEAR_MAX) return 1'b0;
         if (d == span(m, y) && leap(y) != leap(ny)) d = span(m, ny);
         y = ny;
         return 1'b1;
      endfunction

      function void note_word(req_word_type w);
         int unsigned d, m, y, amt, carry;
         status_type st;
         bit ok;
         rsp_word_type exp;
         d = day;
         m = month;
         y = year;
         amt = w.amount;
         st = STS_OK;
         ok = 1'b1;
         case (w.func)
            FUNC_LOAD: begin
               d = (w.load_day != 0) ? w.load_day : dflt_day;
               m = (w.load_month != 0) ? w.load_month : dflt_month;
               y = (w.load_year != 0) ? w.load_year : dflt_year;
               if (m < 1 || m > MONTHS_PER_YEAR) st = STS_BAD_MONTH;
               else if (d < 1 || d > span(m, y)) st = STS_BAD_DAY;
               else if (y < 1 || y > YEAR_MAX) st = STS_YEAR;
               ok = (st == STS_OK);
            end
            FUNC_DAYS: begin
               while (ok && amt + d > span(m, y)) begin
                  amt -= span(m, y) - d + 1;
                  d = 1;
                  m++;
                  if (m > MONTHS_PER_YEAR) begin
                     m = 1;
                     y++;
                     if (y > YEAR_MAX) ok = 1'b0;
                  end
               end
               d += amt;
            end
            FUNC_MONTHS: begin
               if (amt != 0) begin
                  carry = amt / MONTHS_PER_YEAR;
                  m = m + amt % MONTHS_PER_YEAR;
                  if (m > MONTHS_PER_YEAR) begin
                     carry++;
                     m -= MONTHS_PER_YEAR;
                  end
                  if (d > span(m, y)) d = span(m, y);
                  ok = shift_years(d, m, y, carry);
               end
            end
            default: ok = shift_years(d, m, y, amt);
         endcase
         if (w.func != FUNC_LOAD && !ok) st = STS_YEAR;
         if (ok) begin
            day = d & 32'h1f;
            month = m & 32'hf;
            year = y & 32'h3fff;
         end
         exp.cur_day = day[4:0];
         exp.cur_month = month[3:0];
         exp.cur_year = year[13:0];
         exp.status = st;
         pending.push_back(exp);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word %0d/%0d/%0d status %s", $time,
                     got.cur_day, got.cur_month, got.cur_year, got.status.name());
            return;
         end
         exp = pending.pop_front();
         checked++;
         seen[exp.status]++;
         if (got.cur_day != exp.cur_day || got.cur_month != exp.cur_month ||
             got.cur_year != exp.cur_year || got.status != exp.status) begin
            errors++;
            $display("%0t: mismatch expected %0d/%0d/%0d %s, actual %0d/%0d/%0d %s",
                     $time, exp.cur_day, exp.cur_month, exp.cur_year,
                     exp.status.name(), got.cur_day, got.cur_month, got.cur_year,
                     got.status.name());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_word_type req_word;
   logic rsp_valid;
   rsp_word_type rsp_word;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   date_shadow tracker = new();
   int unsigned words_sent = 0;

   calendar_date_adder uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // results first: a word accepted on this edge cannot have answered yet
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) tracker.check_word(rsp_word);
         if (start && !busy) begin
            tracker.note_word(req_word);
            words_sent++;
         end
      end
   end

   function automatic req_word_type make_word(func_type f, int unsigned d, int unsigned m,
                                              int unsigned y, int unsigned amt);
      req_word_type w;
      w.func = f;
      w.load_day = d[4:0];
      w.load_month = m[3:0];
      w.load_year = y[13:0];
      w.amount = amt[15:0];
      return w;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned pick, m, y;
      w = make_word(FUNC_LOAD, $urandom_range(31), $urandom_range(15),
                    $urandom_range(16383), $urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 22) begin
         w.func = FUNC_LOAD;
         if ($urandom_range(99) < 75) begin
            m = $urandom_range(1, 12);
            case ($urandom_range(3))
               0: y = $urandom_range(9980, 9999);
               1: y = $urandom_range(1, 100);
               default: y = $urandom_range(1, 9999);
            endcase
            w.load_month = m[3:0];
            w.load_year = y[13:0];
            w.load_day = 5'($urandom_range(1, tracker.span(m, y)));
            if ($urandom_range(9) == 0) w.load_day = '0;
            if ($urandom_range(9) == 0) w.load_month = '0;
            if ($urandom_range(9) == 0) w.load_year = '0;
         end
      end else if (pick < 52) begin
         w.func = FUNC_DAYS;
         pick = $urandom_range(99);
         if (pick < 70) w.amount = 16'($urandom_range(62));
         else if (pick < 90) w.amount = 16'($urandom_range(1500));
         else if (pick < 98) w.amount = 16'($urandom_range(12000));
      end else if (pick < 72) begin
         w.func = FUNC_MONTHS;
         pick = $urandom_range(99);
         if (pick < 80) w.amount = 16'($urandom_range(40));
         else if (pick < 95) w.amount = 16'($urandom_range(1200));
      end else begin
         w.func = FUNC_YEARS;
         pick = $urandom_range(99);
         if (pick < 70) w.amount = 16'($urandom_range(30));
         else if (pick < 90) w.amount = 16'($urandom_range(500));
      end
      return w;
   endfunction

   task automatic issue_word(input req_word_type w, input int unsigned idle_pct);
      int unsigned gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   // waits for a clock edge before polling, so the word accepted on the last edge is already noted
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (busy || tracker.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_defaults(input int unsigned d, input int unsigned m,
                               input int unsigned y);
      csr_we <= 1'b1;
      csr_addr <= CSR_DEFAULT_DAY;
      csr_wdata <= CSR_DATA_W'(d);
      @(posedge clock);
      csr_addr <= CSR_DEFAULT_MONTH;
      csr_wdata <= CSR_DATA_W'(m);
      @(posedge clock);
      csr_addr <= CSR_DEFAULT_YEAR;
      csr_wdata <= CSR_DATA_W'(y);
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.dflt_day = d;
      tracker.dflt_month = m;
      tracker.dflt_year = y;
   endtask

   initial begin
      int unsigned idle_pct[5] = '{0, 83, 0, 30, 83};
      int unsigned def_day[5] = '{31, 1, 0, 0, 0};
      int unsigned def_month[5] = '{12, 1, 0, 0, 0};
      int unsigned def_year[5] = '{9999, 1, 0, 0, 0};
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_addr = CSR_DEFAULT_DAY;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corners, reset defaults still in place
      issue_word(make_word(FUNC_LOAD, 0, 0, 0, 0), 0);
      issue_word(make_word(FUNC_LOAD, 29, 2, 2000, 65535), 0);
      issue_word(make_word(FUNC_YEARS, 31, 15, 16383, 100), 0);
      issue_word(make_word(FUNC_YEARS, 0, 0, 0, 0), 0);
      issue_word(make_word(FUNC_LOAD, 29, 2, 1900, 0), 0);
      issue_word(make_word(FUNC_LOAD, 10, 13, 2000, 0), 0);
      issue_word(make_word(FUNC_LOAD, 10, 15, 2000, 0), 0);
      issue_word(make_word(FUNC_LOAD, 31, 4, 2001, 0), 0);
      issue_word(make_word(FUNC_LOAD, 1, 1, 10000, 0), 0);
      issue_word(make_word(FUNC_LOAD, 1, 1, 16383, 0), 0);
      issue_word(make_word(FUNC_LOAD, 31, 12, 9999, 0), 0);
      issue_word(make_word(FUNC_DAYS, 0, 0, 0, 1), 0);
      issue_word(make_word(FUNC_MONTHS, 0, 0, 0, 1), 0);
      issue_word(make_word(FUNC_YEARS, 0, 0, 0, 1), 0);
      issue_word(make_word(FUNC_DAYS, 0, 0, 0, 0), 0);
      issue_word(make_word(FUNC_LOAD, 31, 1, 2023, 0), 0);
      issue_word(make_word(FUNC_MONTHS, 0, 0, 0, 13), 0);
      issue_word(make_word(FUNC_MONTHS, 0, 0, 0, 0), 0);
      issue_word(make_word(FUNC_DAYS, 0, 0, 0, 65535), 0);
      issue_word(make_word(FUNC_MONTHS, 0, 0, 0, 65535), 0);
      issue_word(make_word(FUNC_YEARS, 0, 0, 0, 65535), 0);
      issue_word(make_word(FUNC_LOAD, 28, 2, 2023, 0), 0);
      issue_word(make_word(FUNC_DAYS, 0, 0, 0, 1), 0);
      issue_word(make_word(FUNC_LOAD, 1, 1, 1, 0), 0);
      issue_word(make_word(FUNC_DAYS, 0, 0, 0, 365), 0);
      issue_word(make_word(FUNC_LOAD, 29, 2, 2024, 0), 0);
      issue_word(make_word(FUNC_YEARS, 0, 0, 0, 4), 0);

      // phases 2 and 4 pick defaults at random, the last one across full register width
      def_day[2] = $urandom_range(1, 31);
      def_month[2] = $urandom_range(1, 12);
      def_year[2] = $urandom_range(1, 9999);
      def_day[4] = $urandom_range(31);
      def_month[4] = $urandom_range(15);
      def_year[4] = $urandom_range(16383);
      foreach (idle_pct[p]) begin
         settle();
         set_defaults(def_day[p], def_month[p], def_year[p]);
         repeat (100) issue_word(random_word(), idle_pct[p]);
      end
      settle();

      $display("%0d words sent, %0d results checked over directed corners and 5 phases",
               words_sent, tracker.checked);
      $display("status mix: ok %0d, bad month %0d, bad day %0d, year range %0d",
               tracker.seen[STS_OK], tracker.seen[STS_BAD_MONTH],
               tracker.seen[STS_BAD_DAY], tracker.seen[STS_YEAR]);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(64'd100_000_000);
      $display("%0t: timeout, %0d results still outstanding", $time,
               tracker.pending.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
